>>> src/lkt_pkg.sv
// Shared types and constants of the record lock table.
// Holds the transaction payload structs, the table entry layout and the status codes.
// No dependencies.
package lkt_pkg;

  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned FILE_W   = 4;
  localparam int unsigned ROW_W    = 30;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HANDLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENIENT    = 1'b1;

  localparam logic CMD_UNLOCK = 1'b0;
  localparam logic CMD_LOCK   = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LOCKED   = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOT_OPEN = 2'd3
  } status_t;

  typedef struct packed {
    logic                cmd;
    logic [HANDLE_W-1:0] handle;
    logic                handle_open;
    logic                exclusive_open;
    logic [FILE_W-1:0]   file_id;
    logic [ROW_W-1:0]    row;
  } in_item_t;

  typedef struct packed {
    status_t status;
    logic    file_wide_locked;
  } out_item_t;

  // One lock table entry as stored in memory.
  typedef struct packed {
    logic                live;
    logic [FILE_W-1:0]   file_id;
    logic [ROW_W-1:0]    row;
    logic [HANDLE_W-1:0] owner;
  } entry_t;

  // Compare results of one entry against the request.
  typedef struct packed {
    logic live;
    logic file_eq;
    logic row_eq;
    logic owner_eq;
  } cmp_t;

endpackage

>>> src/record_lock_table.sv
// Record lock table top level: request sequencer, file-wide flags and result register.
// Depends on lkt_pkg, lkt_entry_store and lkt_entry_cmp.
//
// A lock or unlock transaction that names a usable handle on a shared table walks the whole
// entry memory through one compare unit, one entry per cycle, then commits at most one write
// (row 0 instead frees matching entries during the walk and updates the handle's file-wide
// flag). The single read port of the entry memory sets the pace of the walk. A transaction
// on an unusable handle or an exclusive table skips the walk and goes straight to its result.
// One transaction is in work at a time; in_ready is high only when the sequencer is idle,
// while a finished result may still wait in the output register. After reset a clearing
// pass marks every entry free; no transaction is accepted during it, configuration writes
// are taken at any time.
module record_lock_table #(
  parameter int unsigned LOCK_ENTRIES = 64,
  parameter int unsigned NUM_HANDLES  = 16,
  parameter int unsigned NUM_FILES    = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [lkt_pkg::CFG_IDX_W-1:0]     cfg_addr,
  input  logic [lkt_pkg::CFG_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lkt_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lkt_pkg::out_item_t                out_data
);
  import lkt_pkg::*;

  localparam int unsigned IDX_W  = $clog2(LOCK_ENTRIES);
  localparam int unsigned CNT_W  = $clog2(LOCK_ENTRIES + 1);
  localparam int unsigned HIDX_W = (NUM_HANDLES > 1) ? $clog2(NUM_HANDLES) : 1;
  localparam logic [CNT_W-1:0] CNT_END  = CNT_W'(LOCK_ENTRIES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LOCK_ENTRIES - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers.
  logic [HANDLE_W-1:0] max_handle;
  logic                lenient_mode;

  // Request held for the whole transaction.
  in_item_t req;
  logic     rel_mode;      // row 0: whole-file release
  status_t  res_status;
  logic     res_zero;      // force file_wide_locked low (not-open result)

  // Scan bookkeeping.
  logic [CNT_W-1:0] issue_cnt;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;
  logic             found;
  logic             found_own;
  logic [IDX_W-1:0] hit_idx;
  logic             free_found;
  logic [IDX_W-1:0] free_idx;

  logic [NUM_HANDLES-1:0] flag_bits;
  logic [HIDX_W-1:0]      hidx;

  // Memory ports and compare unit.
  logic             wr_en;
  logic [IDX_W-1:0] wr_idx;
  entry_t           wr_data;
  logic             rd_en;
  logic [IDX_W-1:0] rd_idx;
  entry_t           rd_data;
  cmp_t             cmp;

  logic    usable;
  logic    may_remove;
  status_t commit_status;

  lkt_entry_store #(
    .LOCK_ENTRIES (LOCK_ENTRIES),
    .IDX_W        (IDX_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_idx  (wr_idx),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_idx  (rd_idx),
    .rd_data (rd_data)
  );

  lkt_entry_cmp u_cmp (
    .entry   (rd_data),
    .file_id (req.file_id),
    .row     (req.row),
    .handle  (req.handle),
    .cmp     (cmp)
  );

  assign in_ready = (state == S_IDLE);
  assign hidx     = HIDX_W'(req.handle);

  // Handle range, file range and open check on the incoming transaction.
  assign usable = in_data.handle_open &&
                  (in_data.handle <= max_handle) &&
                  (32'(in_data.handle) < NUM_HANDLES) &&
                  (32'(in_data.file_id) < NUM_FILES);

  // Another owner's entry may go only in lenient mode.
  assign may_remove = found_own || lenient_mode;

  always_comb begin
    commit_status = ST_OK;
    if (!rel_mode) begin
      if (found) begin
        if (!may_remove) begin
          commit_status = ST_LOCKED;
        end
      end else if (req.cmd == CMD_LOCK && !free_found) begin
        commit_status = ST_FULL;
      end
    end
  end

  // Scan reads walk the memory in order.
  assign rd_en  = (state == S_SCAN) && (issue_cnt != CNT_END);
  assign rd_idx = issue_cnt[IDX_W-1:0];

  // Single write port: clearing pass, release during the scan, or the commit write.
  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = issue_cnt[IDX_W-1:0];
    wr_data = '0;
    unique case (state)
      S_CLEAR: begin
        wr_en = 1'b1;
      end
      S_SCAN: begin
        wr_idx = cmp_idx;
        wr_en  = cmp_valid && rel_mode && cmp.live && cmp.file_eq &&
                 (cmp.owner_eq || lenient_mode);
      end
      S_COMMIT: begin
        if (!rel_mode) begin
          if (found) begin
            // Unlock of a pair this handle may release: drop it.
            wr_idx = hit_idx;
            wr_en  = (req.cmd == CMD_UNLOCK) && may_remove;
          end else if (req.cmd == CMD_LOCK && free_found) begin
            wr_idx          = free_idx;
            wr_en           = 1'b1;
            wr_data.live    = 1'b1;
            wr_data.file_id = req.file_id;
            wr_data.row     = req.row;
            wr_data.owner   = req.handle;
          end
        end
      end
      S_IDLE, S_DONE: begin
        wr_en = 1'b0;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  // Configuration writes, taken in any state.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_handle   <= HANDLE_W'(15);
      lenient_mode <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_MAX_HANDLE: max_handle   <= cfg_wdata[HANDLE_W-1:0];
        CFG_LENIENT:    lenient_mode <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // Sequencer, flags and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      issue_cnt  <= '0;
      cmp_valid  <= 1'b0;
      out_valid  <= 1'b0;
      flag_bits  <= '0;
      found      <= 1'b0;
      free_found <= 1'b0;
    end else begin
      // Drop the result once the consumer takes it, unless a new one loads in its place.
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_CLEAR: begin
          issue_cnt <= issue_cnt + CNT_W'(1);
          if (issue_cnt == CNT_LAST) begin
            state <= S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            req        <= in_data;
            rel_mode   <= (in_data.row == '0);
            issue_cnt  <= '0;
            cmp_valid  <= 1'b0;
            found      <= 1'b0;
            found_own  <= 1'b0;
            free_found <= 1'b0;
            if (!usable) begin
              res_status <= ST_NOT_OPEN;
              res_zero   <= 1'b1;
              state      <= S_DONE;
            end else begin
              res_status <= ST_OK;
              res_zero   <= 1'b0;
              if (in_data.exclusive_open) begin
                state <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end
          end
        end

        S_SCAN: begin
          if (rd_en) begin
            issue_cnt <= issue_cnt + CNT_W'(1);
          end
          cmp_valid <= rd_en;
          cmp_idx   <= rd_idx;
          if (cmp_valid && !rel_mode) begin
            // Record the holder of the pair and the lowest free entry.
            if (cmp.live && cmp.file_eq && cmp.row_eq && !found) begin
              found     <= 1'b1;
              found_own <= cmp.owner_eq;
              hit_idx   <= cmp_idx;
            end
            if (!cmp.live && !free_found) begin
              free_found <= 1'b1;
              free_idx   <= cmp_idx;
            end
          end
          if (!rd_en && !cmp_valid) begin
            state <= S_COMMIT;
          end
        end

        S_COMMIT: begin
          res_status <= commit_status;
          if (rel_mode) begin
            flag_bits[hidx] <= req.cmd;
          end
          state <= S_DONE;
        end

        S_DONE: begin
          // Hold until the output register is free.
          if (!out_valid || out_ready) begin
            out_valid                 <= 1'b1;
            out_data.status           <= res_status;
            out_data.file_wide_locked <= res_zero ? 1'b0 : flag_bits[hidx];
            state                     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The memory is never written while the sequencer waits for a transaction.
  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr_en)
    else $error("entry write while idle");

  // A not-open result never reports a file-wide lock.
  a_not_open_flag: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status == ST_NOT_OPEN) |-> !out_data.file_wide_locked)
    else $error("not-open result with file-wide flag set");

  // An accepted transaction closes the input until it is finished.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after acceptance");

  // The scan never runs past the end of the table.
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (issue_cnt <= CNT_END))
    else $error("scan counter beyond table");

  // A lock commit that reports full saw no free entry and no holder.
  a_full_reason: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMMIT && commit_status == ST_FULL) |-> (!free_found && !found))
    else $error("full reported with a free entry or holder");

endmodule

>>> src/lkt_entry_store.sv
// Lock entry storage: one write port, one registered read port.
// Depends on lkt_pkg for the entry layout.
module lkt_entry_store #(
  parameter int unsigned LOCK_ENTRIES = 64,
  parameter int unsigned IDX_W        = $clog2(LOCK_ENTRIES)
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [IDX_W-1:0]     wr_idx,
  input  lkt_pkg::entry_t      wr_data,
  input  logic                 rd_en,
  input  logic [IDX_W-1:0]     rd_idx,
  output lkt_pkg::entry_t      rd_data
);
  import lkt_pkg::*;

  entry_t mem [LOCK_ENTRIES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_idx];
    end
  end

endmodule

>>> src/lkt_entry_cmp.sv
// Entry compare unit, reused for every entry during a table scan.
// Depends on lkt_pkg for the entry and compare structs.
module lkt_entry_cmp (
  input  lkt_pkg::entry_t                  entry,
  input  logic [lkt_pkg::FILE_W-1:0]       file_id,
  input  logic [lkt_pkg::ROW_W-1:0]        row,
  input  logic [lkt_pkg::HANDLE_W-1:0]     handle,
  output lkt_pkg::cmp_t                    cmp
);
  import lkt_pkg::*;

  always_comb begin
    cmp.live     = entry.live;
    cmp.file_eq  = (entry.file_id == file_id);
    cmp.row_eq   = (entry.row == row);
    cmp.owner_eq = (entry.owner == handle);
  end

endmodule
